@@ rtl/core/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and build-time gain tables for the stereo chorus.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int SW    = 24;            // sample width
    localparam int CW    = 24;            // coefficient register width
    localparam int GW    = 24;            // gain table entry width
    localparam int IDXSH = SW - 9;        // envelope bits below the table index
    localparam int MAW   = 30;            // multiplier operand A width
    localparam int MBW   = 26;            // multiplier operand B width
    localparam int MW    = MAW + MBW;     // product width
    localparam int WW    = 26;            // wet channel width
    localparam int XW    = 28;            // side and matrix output width

    localparam logic [CW-1:0] ONE23 = CW'(64'd1 << 23);
    localparam logic signed [MW-1:0] SMAX_W = (MW'(1) <<< (SW - 1)) - MW'(1);
    localparam logic signed [MW-1:0] SMIN_W = -SMAX_W - MW'(1);

    localparam logic [CW-1:0] HP_RESET    = 24'd8301200;
    localparam logic [CW-1:0] LP_RESET    = 24'd5805900;
    localparam logic [CW-1:0] ATK_RESET   = 24'd8330560;
    localparam logic [CW-1:0] REL_RESET   = 24'd8386667;
    localparam logic [15:0]   WIDTH_RESET = 16'd16384;

    localparam logic [63:0] MAKEUP = 64'd9898557;        // 1.18
    localparam logic signed [MBW-1:0] MID_K  = 26'sd6710886;   // 0.80
    localparam logic signed [MBW-1:0] SIDE_K = 26'sd15099494;  // 1.80
    localparam logic signed [MBW-1:0] TRIM_STD   = 26'sd2652711;  // -10 dB
    localparam logic signed [MBW-1:0] TRIM_BOOST = 26'sd4453381;  // -5.5 dB

    localparam logic [1:0] MODE_BOOST = 2'd3;
    localparam logic [1:0] ROW_SLOW   = 2'd0;
    localparam logic [1:0] ROW_WIDE   = 2'd1;
    localparam logic [1:0] ROW_FAST   = 2'd2;

    localparam logic [2:0] CFG_HP    = 3'd0;
    localparam logic [2:0] CFG_LP    = 3'd1;
    localparam logic [2:0] CFG_ATK   = 3'd2;
    localparam logic [2:0] CFG_REL   = 3'd3;
    localparam logic [2:0] CFG_MODE  = 3'd4;
    localparam logic [2:0] CFG_WIDTH = 3'd5;

    typedef struct packed {
        logic [CW-1:0] hp;
        logic [CW-1:0] lp;
        logic [CW-1:0] atk;
        logic [CW-1:0] rel;
        logic [1:0]    mode;
        logic [15:0]   width;
    } t_cfg;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_MOD_M, S_MOD_P,
        S_HP_M, S_HP_P, S_LP1_M, S_LP1_P, S_ENV_M, S_ENV_P,
        S_CG_M, S_CG_P, S_W_M, S_W_P, S_WRAP, S_RD0, S_RD1,
        S_IP_M, S_IP_P, S_LP2_M, S_LP2_P, S_EG_M, S_EG_P,
        S_WET_M, S_WET_P, S_SIDE_M, S_SIDE_P, S_A_M, S_B_M, S_B_P,
        S_TA_M, S_TA_P, S_TB_M, S_TB_P, S_DONE
    } t_state;

    typedef logic [GW-1:0] t_gtab [0:256];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        int n;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (n = 0; n < 32; n++) begin
            if (b > x) b = b >> 2;
        end
        for (n = 0; n < 32; n++) begin
            if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Restoring long division, used only while the tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int n;
        q   = '0;
        rem = '0;
        for (n = 63; n >= 0; n--) begin
            rem = {rem[63:0], num[n]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[n] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_gtab build_gain(input logic comp_sel);
        t_gtab t;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        int k;
        for (k = 0; k <= 256; k++) begin
            x = 64'd8388608 + ((64'd13421773 * 64'(k) + 64'd128) >> 8);
            s = isqrt64(x << 23);
            if (comp_sel) v = udiv64((MAKEUP << 23) + (s >> 1), s);
            else          v = udiv64((s << 23) + (MAKEUP >> 1), MAKEUP);
            t[k] = v[GW-1:0];
        end
        return t;
    endfunction

    localparam t_gtab COMP_TAB = build_gain(1'b1);
    localparam t_gtab EXP_TAB  = build_gain(1'b0);

    // Round half up, then shift.
    function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] v, input int s);
        return (v + (MW'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [SW-1:0] sat_s(input logic signed [MW-1:0] v);
        if (v > SMAX_W) return SW'(SMAX_W);
        if (v < SMIN_W) return SW'(SMIN_W);
        return SW'(v);
    endfunction

    function automatic logic [CW-1:0] coef(input logic [CW-1:0] c);
        return (c > ONE23) ? ONE23 : c;
    endfunction

endpackage

@@ rtl/core/sbc_dpram.sv @@
// ----------------------------------------------------------------------------
// sbc_dpram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sbc_dpram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/sbc_engine.sv @@
// ----------------------------------------------------------------------------
// sbc_engine
// Sequencer and shared multiply datapath around the two delay memories.
// ----------------------------------------------------------------------------
module sbc_engine #(
    parameter int DELAY_DEPTH = 2048,
    parameter int SAMPLE_RATE = 48000
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sbc_pkg::t_cfg              i_cfg,
    input  logic                       i_start,
    input  logic signed [sbc_pkg::SW-1:0] i_left,
    input  logic signed [sbc_pkg::SW-1:0] i_right,
    input  logic                       i_out_free,
    output logic                       o_ready,
    output logic                       o_done,
    output logic signed [sbc_pkg::SW-1:0] o_left,
    output logic signed [sbc_pkg::SW-1:0] o_right
);
    import sbc_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int QW = AW + 11;
    localparam longint SPAN = longint'(DELAY_DEPTH) * 256;

    localparam longint BASE0 = (longint'(SAMPLE_RATE) * 100 * 256 + 5000) / 10000;
    localparam longint BASE1 = (longint'(SAMPLE_RATE) * 75 * 256 + 5000) / 10000;
    localparam longint DEPR0 = (longint'(SAMPLE_RATE) * 20 * 256 + 5000) / 10000;
    localparam longint DEPR1 = (longint'(SAMPLE_RATE) * 25 * 256 + 5000) / 10000;
    localparam longint DEPR2 = (longint'(SAMPLE_RATE) * 15 * 256 + 5000) / 10000;
    localparam longint MAXD0 = SPAN - BASE0 - 1024;
    localparam longint MAXD1 = SPAN - BASE1 - 1024;
    localparam longint LIM0  = (MAXD0 < 0) ? 0 : MAXD0;
    localparam longint LIM1  = (MAXD1 < 0) ? 0 : MAXD1;
    localparam longint DEP0  = (DEPR0 > LIM0) ? LIM0 : DEPR0;
    localparam longint DEP1  = (DEPR1 > LIM1) ? LIM1 : DEPR1;
    localparam longint DEP2  = (DEPR2 > LIM1) ? LIM1 : DEPR2;
    localparam logic [63:0] INC_SLOW =
        ((64'd25 << 32) + 64'd50 * 64'(SAMPLE_RATE)) / (64'd100 * 64'(SAMPLE_RATE));
    localparam logic [63:0] INC_FAST =
        ((64'd50 << 32) + 64'd50 * 64'(SAMPLE_RATE)) / (64'd100 * 64'(SAMPLE_RATE));

    localparam logic signed [QW-1:0] SPAN_Q  = QW'(SPAN);
    localparam logic signed [QW-1:0] DLY_MIN = QW'(256);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

    t_state r_state, n_state;
    logic   r_ch;
    logic [AW-1:0] r_wp, r_clr;
    logic [31:0]   r_phase;

    logic signed [SW-1:0] r_dry [0:1];
    logic signed [SW-1:0] r_hli [0:1];
    logic signed [SW-1:0] r_hlo [0:1];
    logic signed [SW-1:0] r_pl  [0:1];
    logic signed [SW-1:0] r_pol [0:1];
    logic [SW-2:0]        r_env [0:1];
    logic signed [QW-1:0] r_dly [0:1];
    logic signed [WW-1:0] r_wet [0:1];

    logic signed [QW-1:0] r_pos;
    logic signed [SW-1:0] r_t, r_s0;
    logic [SW-2:0]        r_rect;
    logic [GW-1:0]        r_g0, r_gain;
    logic signed [WW:0]   r_mid;
    logic signed [XW-1:0] r_side, r_wa, r_wb;
    logic signed [MW-1:0] r_p1, r_prod;
    logic signed [SW-1:0] r_ol, r_or;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [SW-1:0]         mem_wdata;
    logic [SW-1:0]         rdata_l, rdata_r;
    logic signed [SW-1:0]  rdata;

    logic [1:0]            row;
    logic signed [QW-1:0]  base_q;
    logic signed [MBW-1:0] depth_q;
    logic [31:0]           inc;
    logic signed [MBW-1:0] trim;
    logic [23:0]           ph_u;
    logic [22:0]           ph_f;
    logic signed [24:0]    tri_v;
    logic [AW-1:0]         i0, i1;
    logic [7:0]            idx;
    logic [8:0]            idx_n;
    logic [CW-1:0]         lc, ec;
    logic signed [MW-1:0]  p_r23, p_r15, p_r14;
    logic signed [QW-1:0]  mod_q, dl_raw, dr_raw;
    logic signed [SW-1:0]  lp1_v;
    logic [SW-2:0]         env_v;

    sbc_dpram #(.DEPTH(DELAY_DEPTH), .WIDTH(SW)) u_ram_l (
        .i_clk  (i_clk),
        .i_we   (mem_we && (r_state == S_CLR || !r_ch)),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(rdata_l)
    );

    sbc_dpram #(.DEPTH(DELAY_DEPTH), .WIDTH(SW)) u_ram_r (
        .i_clk  (i_clk),
        .i_we   (mem_we && (r_state == S_CLR || r_ch)),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(rdata_r)
    );

    assign rdata = r_ch ? $signed(rdata_r) : $signed(rdata_l);

    // Mode table lookup; the boost mode reuses the fast row with a louder trim.
    always_comb begin
        row = (i_cfg.mode == MODE_BOOST) ? ROW_FAST : i_cfg.mode;
        unique case (row)
            ROW_SLOW: begin
                base_q = QW'(BASE0); depth_q = MBW'(DEP0); inc = INC_SLOW[31:0];
            end
            ROW_WIDE: begin
                base_q = QW'(BASE1); depth_q = MBW'(DEP1); inc = INC_SLOW[31:0];
            end
            default: begin
                base_q = QW'(BASE1); depth_q = MBW'(DEP2); inc = INC_FAST[31:0];
            end
        endcase
        trim = (i_cfg.mode == MODE_BOOST) ? TRIM_BOOST : TRIM_STD;
    end

    always_comb begin
        ph_u = r_phase[31:8];
        ph_f = {ph_u[21:0], 1'b0};
        unique case (ph_u[23:22])
            2'd0:    tri_v = $signed({2'b00, ph_f});
            2'd1:    tri_v = 25'sd8388608 - $signed({2'b00, ph_f});
            2'd2:    tri_v = -$signed({2'b00, ph_f});
            default: tri_v = $signed({2'b00, ph_f}) - 25'sd8388608;
        endcase
    end

    always_comb begin
        lc    = coef(i_cfg.lp);
        ec    = (r_rect > r_env[r_ch]) ? coef(i_cfg.atk) : coef(i_cfg.rel);
        i0    = r_pos[AW+7:8];
        i1    = (i0 == LAST_ADDR) ? '0 : i0 + AW'(1);
        idx   = r_env[r_ch][SW-2:IDXSH];
        idx_n = {1'b0, idx} + 9'd1;
        p_r23 = rnd(r_prod, 23);
        p_r15 = rnd(r_prod, IDXSH);
        p_r14 = rnd(r_prod, 14);
        mod_q  = QW'(p_r23);
        dl_raw = base_q + mod_q;
        dr_raw = base_q - mod_q;
        lp1_v  = sat_s(MW'(r_pl[r_ch]) + p_r23);
        env_v  = (SW-1)'(MW'({1'b0, r_rect}) + p_r23);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:   if (i_start) n_state = S_MOD_M;
            S_MOD_M:  n_state = S_MOD_P;
            S_MOD_P:  n_state = S_HP_M;
            S_HP_M:   n_state = S_HP_P;
            S_HP_P:   n_state = S_LP1_M;
            S_LP1_M:  n_state = S_LP1_P;
            S_LP1_P:  n_state = S_ENV_M;
            S_ENV_M:  n_state = S_ENV_P;
            S_ENV_P:  n_state = S_CG_M;
            S_CG_M:   n_state = S_CG_P;
            S_CG_P:   n_state = S_W_M;
            S_W_M:    n_state = S_W_P;
            S_W_P:    n_state = S_WRAP;
            S_WRAP:   if (r_pos >= 0 && r_pos < SPAN_Q) n_state = S_RD0;
            S_RD0:    n_state = S_RD1;
            S_RD1:    n_state = S_IP_M;
            S_IP_M:   n_state = S_IP_P;
            S_IP_P:   n_state = S_LP2_M;
            S_LP2_M:  n_state = S_LP2_P;
            S_LP2_P:  n_state = S_EG_M;
            S_EG_M:   n_state = S_EG_P;
            S_EG_P:   n_state = S_WET_M;
            S_WET_M:  n_state = S_WET_P;
            S_WET_P:  n_state = r_ch ? S_SIDE_M : S_HP_M;
            S_SIDE_M: n_state = S_SIDE_P;
            S_SIDE_P: n_state = S_A_M;
            S_A_M:    n_state = S_B_M;
            S_B_M:    n_state = S_B_P;
            S_B_P:    n_state = S_TA_M;
            S_TA_M:   n_state = S_TA_P;
            S_TA_P:   n_state = S_TB_M;
            S_TB_M:   n_state = S_TB_P;
            S_TB_P:   n_state = S_DONE;
            S_DONE:   if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Multiplier operands and memory controls.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_wp;
        mem_wdata = '0;
        mem_raddr = i0;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_MOD_M: begin
                mul_a = MAW'(tri_v);
                mul_b = depth_q;
            end
            S_HP_M: begin
                mul_a = $signed({6'b0, coef(i_cfg.hp)});
                mul_b = MBW'(r_hlo[r_ch]) + MBW'(r_dry[r_ch]) - MBW'(r_hli[r_ch]);
            end
            S_LP1_M: begin
                mul_a = $signed({6'b0, lc});
                mul_b = MBW'(r_t) - MBW'(r_pl[r_ch]);
            end
            S_ENV_M: begin
                mul_a = $signed({6'b0, ec});
                mul_b = $signed({3'b0, r_env[r_ch]}) - $signed({3'b0, r_rect});
            end
            S_CG_M: begin
                mul_a = $signed({15'b0, r_env[r_ch][IDXSH-1:0]});
                mul_b = $signed({2'b0, COMP_TAB[idx_n]}) - $signed({2'b0, COMP_TAB[idx]});
            end
            S_W_M, S_WET_M: begin
                mul_a = MAW'(r_t);
                mul_b = $signed({2'b0, r_gain});
            end
            S_W_P: begin
                mem_we    = 1'b1;
                mem_wdata = sat_s(p_r23);
            end
            S_RD1: mem_raddr = i1;
            S_IP_M: begin
                mul_a = MAW'(rdata) - MAW'(r_s0);
                mul_b = $signed({18'b0, r_pos[7:0]});
            end
            S_LP2_M: begin
                mul_a = $signed({6'b0, lc});
                mul_b = MBW'(r_t) - MBW'(r_pol[r_ch]);
            end
            S_EG_M: begin
                mul_a = $signed({15'b0, r_env[r_ch][IDXSH-1:0]});
                mul_b = $signed({2'b0, EXP_TAB[idx_n]}) - $signed({2'b0, EXP_TAB[idx]});
            end
            S_SIDE_M: begin
                mul_a = MAW'(r_wet[0]) - MAW'(r_wet[1]);
                mul_b = $signed({10'b0, i_cfg.width});
            end
            S_A_M: begin
                mul_a = MAW'(r_mid);
                mul_b = MID_K;
            end
            S_B_M: begin
                mul_a = MAW'(r_side);
                mul_b = SIDE_K;
            end
            S_TA_M: begin
                mul_a = MAW'(r_wa);
                mul_b = trim;
            end
            S_TB_M: begin
                mul_a = MAW'(r_wb);
                mul_b = trim;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= 1'b0;
            r_wp    <= '0;
            r_clr   <= '0;
            r_phase <= '0;
            for (int c = 0; c < 2; c++) begin
                r_hli[c] <= '0;
                r_hlo[c] <= '0;
                r_pl[c]  <= '0;
                r_pol[c] <= '0;
                r_env[c] <= '0;
            end
        end else begin
            unique case (r_state)
                S_CLR:  r_clr <= r_clr + AW'(1);
                S_IDLE: r_ch  <= 1'b0;
                S_HP_P: begin
                    r_hli[r_ch] <= r_dry[r_ch];
                    r_hlo[r_ch] <= sat_s(p_r23);
                end
                S_LP1_P: r_pl[r_ch]  <= lp1_v;
                S_ENV_P: r_env[r_ch] <= env_v;
                S_LP2_P: r_pol[r_ch] <= sat_s(MW'(r_pol[r_ch]) + p_r23);
                S_WET_P: r_ch <= ~r_ch;
                S_DONE: begin
                    if (i_out_free) begin
                        r_wp    <= (r_wp == LAST_ADDR) ? '0 : r_wp + AW'(1);
                        r_phase <= r_phase + inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_dry[0] <= i_left;
                    r_dry[1] <= i_right;
                end
            end
            S_MOD_P: begin
                r_dly[0] <= (dl_raw < DLY_MIN) ? DLY_MIN : dl_raw;
                r_dly[1] <= (dr_raw < DLY_MIN) ? DLY_MIN : dr_raw;
            end
            S_HP_P: r_t <= sat_s(p_r23);
            S_LP1_P: begin
                r_t <= lp1_v;
                // The most negative sample rectifies to the largest positive one.
                r_rect <= (lp1_v == SW'(SMIN_W)) ? SMAX_W[SW-2:0]
                        : (lp1_v[SW-1] ? (SW-1)'(-lp1_v) : lp1_v[SW-2:0]);
            end
            S_CG_M: r_g0 <= COMP_TAB[idx];
            S_EG_M: r_g0 <= EXP_TAB[idx];
            S_CG_P, S_EG_P: r_gain <= GW'(MW'({1'b0, r_g0}) + p_r15);
            S_W_P:  r_pos <= $signed({3'b000, r_wp, 8'h00}) - r_dly[r_ch];
            S_WRAP: begin
                if (r_pos < 0)            r_pos <= r_pos + SPAN_Q;
                else if (r_pos >= SPAN_Q) r_pos <= r_pos - SPAN_Q;
            end
            S_RD1:   r_s0 <= rdata;
            S_IP_P:  r_t  <= SW'(rnd((MW'(r_s0) <<< 8) + r_prod, 8));
            S_LP2_P: r_t  <= sat_s(MW'(r_pol[r_ch]) + p_r23);
            S_WET_P: r_wet[r_ch] <= WW'(p_r23);
            S_SIDE_M: r_mid <= (WW+1)'(r_wet[0]) + (WW+1)'(r_wet[1]);
            S_SIDE_P: r_side <= XW'(p_r14);
            S_B_M:   r_p1 <= r_prod;
            S_B_P: begin
                r_wa <= XW'(rnd(r_p1 + r_prod, 24));
                r_wb <= XW'(rnd(r_p1 - r_prod, 24));
            end
            S_TA_P: r_ol <= sat_s(MW'(r_dry[0]) + p_r23);
            S_TB_P: r_or <= sat_s(MW'(r_dry[1]) + p_r23);
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_out_free;
    assign o_left  = r_ol;
    assign o_right = r_or;
endmodule

@@ rtl/core/stereo_bbd_chorus_top.sv @@
// ----------------------------------------------------------------------------
// stereo_bbd_chorus_top
// Stereo chorus with compander: configuration registers, handshakes and
// output register around the sequenced processing engine.
// ----------------------------------------------------------------------------
//   channel   valid         stall         payload
//   input     i_in_valid    o_in_stall    i_left_in, i_right_in
//   output    o_out_valid   i_out_stall   o_left_out, o_right_out
//   config    i_cfg_we      (none)        i_cfg_idx, i_cfg_data
//
// Every filter, gain and mix step of a stereo word runs on the single shared
// multiplier, one step after another. A channel whose read position wraps
// below zero stays an extra step in the wrap state before its delay read.
// After reset both delay memories are zeroed, one entry per cycle; no word is
// taken during that time.
// A finished word waits in the output register; the engine accepts the next
// input word meanwhile and holds its own result until that register frees up.
// ----------------------------------------------------------------------------
module stereo_bbd_chorus_top #(
    parameter int DELAY_DEPTH = 2048,
    parameter int SAMPLE_RATE = 48000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [sbc_pkg::SW-1:0] i_left_in,
    input  logic signed [sbc_pkg::SW-1:0] i_right_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [sbc_pkg::SW-1:0] o_left_out,
    output logic signed [sbc_pkg::SW-1:0] o_right_out,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [sbc_pkg::CW-1:0]        i_cfg_data
);
    import sbc_pkg::*;

    t_cfg r_cfg;
    logic r_out_valid;
    logic signed [SW-1:0] r_left_out, r_right_out;
    logic eng_ready, eng_done, out_free;
    logic signed [SW-1:0] eng_left, eng_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hp    <= HP_RESET;
            r_cfg.lp    <= LP_RESET;
            r_cfg.atk   <= ATK_RESET;
            r_cfg.rel   <= REL_RESET;
            r_cfg.mode  <= '0;
            r_cfg.width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HP:    r_cfg.hp    <= i_cfg_data;
                CFG_LP:    r_cfg.lp    <= i_cfg_data;
                CFG_ATK:   r_cfg.atk   <= i_cfg_data;
                CFG_REL:   r_cfg.rel   <= i_cfg_data;
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[1:0];
                CFG_WIDTH: r_cfg.width <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    sbc_engine #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_RATE(SAMPLE_RATE)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_start   (i_in_valid && eng_ready),
        .i_left    (i_left_in),
        .i_right   (i_right_in),
        .i_out_free(out_free),
        .o_ready   (eng_ready),
        .o_done    (eng_done),
        .o_left    (eng_left),
        .o_right   (eng_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_left_out  <= eng_left;
            r_right_out <= eng_right;
        end
    end

    assign o_in_stall  = !eng_ready;
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;
endmodule

@@ rtl/core/sbc_checker.sv @@
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the chorus top level, attached by bind.
// ----------------------------------------------------------------------------
module sbc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [sbc_pkg::SW-1:0] o_left_out,
    input logic signed [sbc_pkg::SW-1:0] o_right_out
);
    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The engine works on one word at a time.
    a_busy_after_accept: assert property (@(posedge i_clk)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is still in work");

    // A new result only comes out of a busy engine.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_left_out) && $stable(o_right_out)))
        else $error("stalled output changed");
endmodule

bind stereo_bbd_chorus_top sbc_checker u_sbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_left_out (o_left_out),
    .o_right_out(o_right_out)
);

@@ dv/stereo_bbd_chorus_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_bbd_chorus_top_test
// Drives stereo sample words through the chorus under random idling on both
// channels and checks every output word against a bit-exact predictor that
// carries its own filter, envelope, delay-line and LFO state.
// ----------------------------------------------------------------------------
module stereo_bbd_chorus_top_test;
    import sbc_pkg::*;

    localparam int      DEPTH       = 2048;
    localparam longint  RATE        = 48000;
    localparam longint  UNITY       = 64'sd8388608;
    localparam longint  PEAK        = 64'sd8388607;
    localparam longint  MAKEUP_Q23  = 64'sd9898557;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
    } t_pair;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [SW-1:0] i_left_in;
    logic signed [SW-1:0] i_right_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [SW-1:0] o_left_out;
    logic signed [SW-1:0] o_right_out;
    logic                 i_cfg_we;
    logic [2:0]           i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;

    stereo_bbd_chorus_top DUT (.*);

    // Predictor state.
    longint      cfg_hp, cfg_lp, cfg_atk, cfg_rel, cfg_mode, cfg_side;
    longint      delay_line [2][DEPTH];
    longint      hp_in_prev [2], hp_out_prev [2], smooth_pre [2], smooth_post [2];
    longint      env_level [2];
    int          wr_ptr;
    logic [31:0] lfo_acc;
    longint      comp_gain [257], expand_gain [257];
    longint      row_base [3], row_depth [3];
    logic [31:0] row_inc [3];

    t_pair       pending_words [$];
    int          fail_count;
    bit          idle_on;
    int          stall_left;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v);
        if (v > PEAK) return PEAK;
        if (v < -PEAK - 1) return -PEAK - 1;
        return v;
    endfunction

    function automatic longint limit_coef(longint c);
        return (c > UNITY) ? UNITY : c;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return longint'(r);
    endfunction

    function automatic longint gain_lookup(bit comp, longint env);
        longint i;
        longint f;
        longint g0;
        longint g1;
        i  = (env >>> IDXSH) & 255;
        f  = env & ((64'sd1 <<< IDXSH) - 1);
        g0 = comp ? comp_gain[i] : expand_gain[i];
        g1 = comp ? comp_gain[i + 1] : expand_gain[i + 1];
        return g0 + rnd_shift((g1 - g0) * f, IDXSH);
    endfunction

    function automatic longint chorus_channel(int c, longint x, longint dly);
        longint hp, lp1, rect, ec, env, w, pos, i0, i1, fr, rd, lp2, lc;
        lc  = limit_coef(cfg_lp);
        hp  = clip(rnd_shift(limit_coef(cfg_hp) * (hp_out_prev[c] + x - hp_in_prev[c]), 23));
        hp_in_prev[c]  = x;
        hp_out_prev[c] = hp;
        lp1 = clip(smooth_pre[c] + rnd_shift(lc * (hp - smooth_pre[c]), 23));
        smooth_pre[c] = lp1;
        rect = (lp1 < 0) ? -lp1 : lp1;
        if (rect > PEAK) rect = PEAK;
        env = env_level[c];
        ec  = limit_coef(rect > env ? cfg_atk : cfg_rel);
        env = rnd_shift(ec * env + (UNITY - ec) * rect, 23);
        env_level[c] = env;
        w = clip(rnd_shift(lp1 * gain_lookup(1'b1, env), 23));
        delay_line[c][wr_ptr] = w;
        if (dly < 256) dly = 256;
        pos = (longint'(wr_ptr) * 256 - dly) % (longint'(DEPTH) * 256);
        if (pos < 0) pos += longint'(DEPTH) * 256;
        i0 = pos >>> 8;
        fr = pos & 255;
        i1 = (i0 + 1 < DEPTH) ? i0 + 1 : 0;
        rd = rnd_shift(delay_line[c][i0] * (256 - fr) + delay_line[c][i1] * fr, 8);
        lp2 = clip(smooth_post[c] + rnd_shift(lc * (rd - smooth_post[c]), 23));
        smooth_post[c] = lp2;
        return rnd_shift(lp2 * gain_lookup(1'b0, env), 23);
    endfunction

    function automatic void predict_word(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
        int          row;
        longint      base, dep, maxd, tri_val, md, wl, wr, mid2, side2, wa, wb, trim;
        logic [23:0] u;
        longint      f;
        t_pair       p;
        row  = (cfg_mode == MODE_BOOST) ? ROW_FAST : int'(cfg_mode);
        base = row_base[row];
        dep  = row_depth[row];
        maxd = longint'(DEPTH) * 256 - base - 1024;
        if (maxd < 0) maxd = 0;
        if (dep > maxd) dep = maxd;
        u = lfo_acc[31:8];
        f = longint'(u[21:0]) << 1;
        case (u[23:22])
            2'd0: tri_val = f;
            2'd1: tri_val = UNITY - f;
            2'd2: tri_val = -f;
            default: tri_val = f - UNITY;
        endcase
        lfo_acc += row_inc[row];
        md = rnd_shift(dep * tri_val, 23);
        wl = chorus_channel(0, longint'(l), base + md);
        wr = chorus_channel(1, longint'(r), base - md);
        wr_ptr = (wr_ptr + 1) % DEPTH;
        mid2  = wl + wr;
        side2 = rnd_shift((wl - wr) * cfg_side, 14);
        wa    = rnd_shift(64'sd6710886 * mid2 + 64'sd15099494 * side2, 24);
        wb    = rnd_shift(64'sd6710886 * mid2 - 64'sd15099494 * side2, 24);
        trim  = (cfg_mode == MODE_BOOST) ? 64'sd4453381 : 64'sd2652711;
        p.l = SW'(clip(longint'(l) + rnd_shift(wa * trim, 23)));
        p.r = SW'(clip(longint'(r) + rnd_shift(wb * trim, 23)));
        pending_words.push_back(p);
    endfunction

    function automatic void model_reset();
        longint unsigned x;
        longint s;
        cfg_hp = 8301200;  cfg_lp = 5805900;
        cfg_atk = 8330560; cfg_rel = 8386667;
        cfg_mode = 0;      cfg_side = 16384;
        for (int i = 0; i < DEPTH; i++) begin
            delay_line[0][i] = 0;
            delay_line[1][i] = 0;
        end
        for (int c = 0; c < 2; c++) begin
            hp_in_prev[c] = 0; hp_out_prev[c] = 0;
            smooth_pre[c] = 0; smooth_post[c] = 0; env_level[c] = 0;
        end
        wr_ptr  = 0;
        lfo_acc = '0;
        for (int k = 0; k <= 256; k++) begin
            x = 64'd8388608 + (64'd13421773 * k + 64'd128) / 64'd256;
            s = int_sqrt(x << 23);
            comp_gain[k]   = ((MAKEUP_Q23 <<< 23) + s / 2) / s;
            expand_gain[k] = ((s <<< 23) + MAKEUP_Q23 / 2) / MAKEUP_Q23;
        end
        // Delay times in samples with 8 fraction bits, from tenths of a millisecond.
        row_base[0]  = (RATE * 100 * 256 + 5000) / 10000;
        row_base[1]  = (RATE * 75 * 256 + 5000) / 10000;
        row_base[2]  = row_base[1];
        row_depth[0] = (RATE * 20 * 256 + 5000) / 10000;
        row_depth[1] = (RATE * 25 * 256 + 5000) / 10000;
        row_depth[2] = (RATE * 15 * 256 + 5000) / 10000;
        row_inc[0]   = 32'(((64'd25 << 32) + 64'd50 * RATE) / (64'd100 * RATE));
        row_inc[1]   = row_inc[0];
        row_inc[2]   = 32'(((64'd50 << 32) + 64'd50 * RATE) / (64'd100 * RATE));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("stereo_bbd_chorus_top verification failed");
        $finish;
    end

    // Output side stalls in random bursts.
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 15);
            i_out_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_pair p;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected output word left_out=%0d right_out=%0d",
                       o_left_out, o_right_out);
                fail_count++;
            end else begin
                p = pending_words.pop_front();
                if (o_left_out !== p.l) begin
                    $error("left_out expected %0d actual %0d", p.l, o_left_out);
                    fail_count++;
                end
                if (o_right_out !== p.r) begin
                    $error("right_out expected %0d actual %0d", p.r, o_right_out);
                    fail_count++;
                end
            end
        end
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_word(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
        bit taken;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_left_in  = l;
        i_right_in = r;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                taken = 1'b1;
                predict_word(l, r);
            end
            @(negedge i_clk);
        end
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CW-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_HP:    cfg_hp   = longint'(data);
            CFG_LP:    cfg_lp   = longint'(data);
            CFG_ATK:   cfg_atk  = longint'(data);
            CFG_REL:   cfg_rel  = longint'(data);
            CFG_MODE:  cfg_mode = longint'(data[1:0]);
            CFG_WIDTH: cfg_side = longint'(data[15:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return SW'($urandom);
            1: return SW'($urandom) >>> $urandom_range(4, 20);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return SW'(($urandom & 24'hFFFFFF)) >>> 2;
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_coef();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return ONE23;
            2: return 24'hFFFFFF;
            3: return CW'($urandom);
            default: return CW'($urandom_range(7000000, 8388608));
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_word('0, '0);
        send_word(24'sh7FFFFF, 24'sh7FFFFF);
        send_word(24'sh800000, 24'sh800000);
        send_word(24'sh7FFFFF, 24'sh800000);
        send_word(24'sh800000, 24'sh7FFFFF);
        send_word(-24'sd1, 24'sd1);
        send_word(24'sh555555, 24'shAAAAAA);
        send_word(24'shAAAAAA, 24'sh555555);
        // A loud burst drives the envelope up, then silence lets it release.
        repeat (6) send_word(24'sh800000, 24'sh7FFFFF);
        repeat (6) send_word('0, '0);
    endtask

    task automatic test_register_extremes();
        logic [CW-1:0] c;
        for (int m = 0; m < 4; m++) begin
            drain();
            c = (m == 0) ? '0 : (m == 1) ? 24'hFFFFFF : (m == 2) ? ONE23 : 24'd1;
            write_reg(CFG_HP, c);
            write_reg(CFG_LP, c);
            write_reg(CFG_ATK, (m == 3) ? 24'hFFFFFF : c);
            write_reg(CFG_REL, (m == 2) ? '0 : c);
            write_reg(CFG_MODE, {((m & 1) != 0) ? 22'h3FFFFF : 22'h0, 2'(m)});
            write_reg(CFG_WIDTH, (m == 0) ? '0 : (m == 1) ? 24'hFFFFFF : 24'd32768);
            // Writes to unused indexes must leave every register alone.
            write_reg(CFG_SPARE_6, CW'($urandom));
            write_reg(CFG_SPARE_7, CW'($urandom));
            repeat (30) send_word(pick_sample(), pick_sample());
        end
    endtask

    task automatic test_random_program(int phases, bit with_idle);
        idle_on = with_idle;
        for (int p = 0; p < phases; p++) begin
            drain();
            write_reg(CFG_HP, pick_coef());
            write_reg(CFG_LP, pick_coef());
            write_reg(CFG_ATK, pick_coef());
            write_reg(CFG_REL, pick_coef());
            write_reg(CFG_MODE, CW'($urandom));
            write_reg(CFG_WIDTH, $urandom_range(0, 1) ? CW'($urandom_range(0, 32768))
                                                      : CW'($urandom));
            repeat (150) send_word(pick_sample(), pick_sample());
        end
    endtask

    initial begin
        fail_count = 0;
        idle_on    = 1'b1;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_left_in  = '0;
        i_right_in = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_HP;
        i_cfg_data = '0;
        model_reset();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_register_extremes();
        test_random_program(8, 1'b1);
        test_random_program(2, 1'b0);

        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("stereo_bbd_chorus_top verification clean");
        else
            $display("stereo_bbd_chorus_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sbc_pkg.sv
rtl/core/sbc_dpram.sv
rtl/core/sbc_engine.sv
rtl/core/stereo_bbd_chorus_top.sv
rtl/core/sbc_checker.sv
dv/stereo_bbd_chorus_top_test.sv
